[hdl/edidx_pkg.sv]
// edidx_pkg: shared types and constants for the edid id and name extractor
// depends on nothing; imported by every module of the block
`default_nettype none

package edidx_pkg;

   // layout of the base block
   localparam logic [7:0] BLOCK_LEN      = 8'd128;
   localparam logic [7:0] VENDOR_HI_POS  = 8'd8;
   localparam logic [7:0] VENDOR_LO_POS  = 8'd9;
   localparam logic [7:0] DESC_START     = 8'd54;
   localparam logic [7:0] DESC_END       = 8'd126;

   // offsets within one 18-byte descriptor
   localparam logic [4:0] REL_HDR_FIRST  = 5'd0;
   localparam logic [4:0] REL_HDR_SECOND = 5'd1;
   localparam logic [4:0] REL_HDR_THIRD  = 5'd2;
   localparam logic [4:0] REL_TAG        = 5'd3;
   localparam logic [4:0] REL_RESERVED   = 5'd4;
   localparam logic [4:0] REL_LAST       = 5'd17;

   // character codes
   localparam logic [7:0] NAME_TAG       = 8'hFC;
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;
   localparam logic [2:0] LETTER_BASE    = 3'b010;  // 64 as the top bits of a letter

   // largest name the block can hold
   localparam int STORE_DEPTH = 13;

   // one finished run, handed from the front part to the back part
   typedef struct packed {
      logic                        status;
      logic [7:0]                  letter_a;
      logic [7:0]                  letter_b;
      logic [7:0]                  letter_c;
      logic                        name_present;
      logic [3:0]                  name_length;
      logic [STORE_DEPTH-1:0][7:0] name;
   } run_summary_type;

   // handshake between the front part and the queue
   typedef struct packed {
      logic            push;
      run_summary_type data;
   } push_word_type;

endpackage

`default_nettype wire

[hdl/edidx_ifs.sv]
// edidx_ifs: valid/ready channel interfaces for edid bytes and name results
// stand alone; used by the top level, the front part and the back part
`default_nettype none

// byte channel into the block
interface edidx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] edid_byte;
   logic       last_byte;

   modport source (output valid, edid_byte, last_byte, input ready);
   modport sink   (input valid, edid_byte, last_byte, output ready);
endinterface

// result channel out of the block
interface edidx_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] vendor_letter_a;
   logic [7:0] vendor_letter_b;
   logic [7:0] vendor_letter_c;
   logic       name_present;
   logic [3:0] name_length;
   logic [3:0] char_index;
   logic [7:0] name_char;
   logic       last_result;

   modport source (output valid, status, vendor_letter_a, vendor_letter_b, vendor_letter_c,
                   name_present, name_length, char_index, name_char, last_result,
                   input ready);
   modport sink   (input valid, status, vendor_letter_a, vendor_letter_b, vendor_letter_c,
                   name_present, name_length, char_index, name_char, last_result,
                   output ready);
endinterface

`default_nettype wire

[hdl/edidx_front.sv]
// edidx_front: parses incoming bytes, keeps vendor bytes and the captured name,
// and pushes one run summary on the last byte; depends on edidx_pkg, edidx_ifs
`default_nettype none

module edidx_front
   import edidx_pkg::*;
#(
   parameter int NAME_CAPACITY = 13
) (
   input  wire logic   clock,
   input  wire logic   reset,
   edidx_req_if.sink   req_if,
   input  wire logic   queue_full,
   output push_word_type push_word
);

   localparam int IDX_W = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;
   localparam logic [3:0] CAP = 4'(NAME_CAPACITY);

   logic [7:0] pos_ff, pos_in;
   logic [4:0] rel_ff, rel_in;
   logic [7:0] vendor_high_ff, vendor_high_in;
   logic [7:0] vendor_low_ff, vendor_low_in;
   logic       hdr_match_ff, hdr_match_in;
   logic       capture_ff, capture_in;
   logic       name_done_ff, name_done_in;
   logic [3:0] captured_ff, captured_in;
   logic [3:0] trimmed_ff, trimmed_in;
   logic [7:0] store_ff [NAME_CAPACITY];

   logic       accept;
   logic       store_wr;
   logic [7:0] store_char;
   logic [7:0] b;
   logic       short_buf;
   logic [STORE_DEPTH-1:0][7:0] name_flat;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.edid_byte;

   // name bytes laid out for the summary, zero above the capacity
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_name
      if (i < NAME_CAPACITY) begin : g_used
         assign name_flat[i] = store_ff[i];
      end else begin : g_unused
         assign name_flat[i] = CHAR_NUL;
      end
   end

   // per-byte parse and end-of-run summary
   always_comb begin
      pos_in         = pos_ff;
      rel_in         = rel_ff;
      vendor_high_in = vendor_high_ff;
      vendor_low_in  = vendor_low_ff;
      hdr_match_in   = hdr_match_ff;
      capture_in     = capture_ff;
      name_done_in   = name_done_ff;
      captured_in    = captured_ff;
      trimmed_in     = trimmed_ff;
      store_wr       = 1'b0;
      store_char     = (b >= CHAR_SPACE && b <= CHAR_TILDE) ? b : CHAR_SPACE;
      push_word      = '0;

      if (accept && pos_ff < BLOCK_LEN) begin
         pos_in = pos_ff + 8'd1;
         if (pos_ff == VENDOR_HI_POS) vendor_high_in = b;
         if (pos_ff == VENDOR_LO_POS) vendor_low_in = b;
         if (pos_ff >= DESC_START && pos_ff < DESC_END) begin
            rel_in = (rel_ff == REL_LAST) ? 5'd0 : rel_ff + 5'd1;
            unique case (rel_ff) inside
               REL_HDR_FIRST: begin
                  capture_in   = 1'b0;
                  hdr_match_in = !name_done_ff && b == CHAR_NUL;
               end
               REL_HDR_SECOND, REL_HDR_THIRD: begin
                  hdr_match_in = hdr_match_ff && b == CHAR_NUL;
               end
               REL_TAG: begin
                  if (hdr_match_ff && b == NAME_TAG) begin
                     name_done_in = 1'b1;
                     capture_in   = 1'b1;
                  end
                  hdr_match_in = 1'b0;
               end
               REL_RESERVED: begin
               end
               default: begin
                  if (capture_ff) begin
                     if (b == CHAR_LF || b == CHAR_CR || b == CHAR_NUL) begin
                        capture_in = 1'b0;
                     end else if (captured_ff < CAP) begin
                        store_wr    = 1'b1;
                        captured_in = captured_ff + 4'd1;
                        if (store_char != CHAR_SPACE) trimmed_in = captured_ff + 4'd1;
                        if (captured_ff + 4'd1 >= CAP) capture_in = 1'b0;
                     end else begin
                        capture_in = 1'b0;
                     end
                  end
                  if (rel_ff == REL_LAST) capture_in = 1'b0;
               end
            endcase
         end
      end

      // summary of the run on the last word, then back to a fresh run
      short_buf = pos_in < BLOCK_LEN;
      if (accept && req_if.last_byte) begin
         push_word.push               = 1'b1;
         push_word.data.status        = short_buf;
         push_word.data.letter_a      = {LETTER_BASE, vendor_high_in[6:2]};
         push_word.data.letter_b      = {LETTER_BASE, vendor_high_in[1:0], vendor_low_in[7:5]};
         push_word.data.letter_c      = {LETTER_BASE, vendor_low_in[4:0]};
         push_word.data.name_present  = !short_buf && captured_in != 4'd0;
         push_word.data.name_length   = short_buf ? 4'd0 : trimmed_in;
         push_word.data.name          = name_flat;
         pos_in         = '0;
         rel_in         = '0;
         vendor_high_in = '0;
         vendor_low_in  = '0;
         hdr_match_in   = 1'b0;
         capture_in     = 1'b0;
         name_done_in   = 1'b0;
         captured_in    = '0;
         trimmed_in     = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         rel_ff         <= '0;
         vendor_high_ff <= '0;
         vendor_low_ff  <= '0;
         hdr_match_ff   <= 1'b0;
         capture_ff     <= 1'b0;
         name_done_ff   <= 1'b0;
         captured_ff    <= '0;
         trimmed_ff     <= '0;
      end else begin
         pos_ff         <= pos_in;
         rel_ff         <= rel_in;
         vendor_high_ff <= vendor_high_in;
         vendor_low_ff  <= vendor_low_in;
         hdr_match_ff   <= hdr_match_in;
         capture_ff     <= capture_in;
         name_done_ff   <= name_done_in;
         captured_ff    <= captured_in;
         trimmed_ff     <= trimmed_in;
      end
   end

   // name store, written at the capture count
   always_ff @(posedge clock) begin
      if (store_wr) store_ff[captured_ff[IDX_W-1:0]] <= store_char;
   end

endmodule

`default_nettype wire

[hdl/edidx_queue.sv]
// edidx_queue: two-entry queue of run summaries between the front and back parts
// depends on edidx_pkg
`default_nettype none

module edidx_queue
   import edidx_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire push_word_type push_word,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output run_summary_type head_data
);

   run_summary_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_word.push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_word.data;
   end

endmodule

`default_nettype wire

[hdl/edidx_back.sv]
// edidx_back: walks the name of the summary at the queue head and sends one result word
// per character (one if empty) via an output register; depends on edidx_pkg, edidx_ifs
`default_nettype none

module edidx_back
   import edidx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire run_summary_type head_data,
   output logic            pop,
   edidx_rsp_if.source     rsp_if
);

   logic [3:0] k_ff, k_in;
   logic       valid_ff, valid_in;
   logic       status_ff, name_present_ff, last_ff;
   logic [7:0] letter_a_ff, letter_b_ff, letter_c_ff, char_ff;
   logic [3:0] length_ff, index_ff;
   logic       load, is_last;
   logic [7:0] char_sel;

   assign load    = head_valid && (!valid_ff || rsp_if.ready);
   assign is_last = ({1'b0, k_ff} + 5'd1) >= {1'b0, head_data.name_length};
   assign pop     = load && is_last;

   // character counter and output valid
   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      char_sel = (head_data.name_length != 4'd0) ? head_data.name[k_ff] : CHAR_NUL;
      if (load) begin
         valid_in = 1'b1;
         k_in     = is_last ? 4'd0 : k_ff + 4'd1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff       <= head_data.status;
         letter_a_ff     <= head_data.letter_a;
         letter_b_ff     <= head_data.letter_b;
         letter_c_ff     <= head_data.letter_c;
         name_present_ff <= head_data.name_present;
         length_ff       <= head_data.name_length;
         index_ff        <= k_ff;
         char_ff         <= char_sel;
         last_ff         <= is_last;
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.status          = status_ff;
   assign rsp_if.vendor_letter_a = letter_a_ff;
   assign rsp_if.vendor_letter_b = letter_b_ff;
   assign rsp_if.vendor_letter_c = letter_c_ff;
   assign rsp_if.name_present    = name_present_ff;
   assign rsp_if.name_length     = length_ff;
   assign rsp_if.char_index      = index_ff;
   assign rsp_if.name_char       = char_ff;
   assign rsp_if.last_result     = last_ff;

endmodule

`default_nettype wire

[hdl/edid_id_and_name_extractor_top.sv]
// edid_id_and_name_extractor_top: one edid byte per cycle in while the queue is not
// full; results leave one word per cycle while the receiver is ready.
// a run yields max(1, name length) words; the back part's output register sets
// the result rate and the two-entry summary queue lets input continue meanwhile.
// synchronous active-high reset clears all run state; the name store keeps its data.
// depends on edidx_pkg, edidx_ifs, edidx_front, edidx_queue, edidx_back
`default_nettype none

module edid_id_and_name_extractor_top
   import edidx_pkg::*;
#(
   parameter int NAME_CAPACITY = 13
) (
   input  wire logic   clock,
   input  wire logic   reset,
   edidx_req_if.sink   req_if,
   edidx_rsp_if.source rsp_if
);

   push_word_type   push_word;
   logic            queue_full;
   logic            pop;
   logic            head_valid;
   run_summary_type head_data;

   // byte parsing and name capture
   edidx_front #(.NAME_CAPACITY(NAME_CAPACITY)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_word  (push_word)
   );

   // run summaries waiting for the back part
   edidx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_word  (push_word),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // result word generation
   edidx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

[verif/tb_edid_id_and_name_extractor_top.sv]
// tb_edid_id_and_name_extractor_top: self-checking bench for the edid id and name extractor
// streams directed and random edid buffers through the valid/ready channels and checks
// every result word; depends on edidx_pkg, edidx_ifs and edid_id_and_name_extractor_top
`timescale 1ns / 1ps

module tb_edid_id_and_name_extractor_top;
   import edidx_pkg::*;

   localparam int NAME_CAP    = 13;
   localparam int DESC_BYTES  = 18;
   localparam int MAX_RUN     = 160;
   localparam int STALL_LIMIT = 5000;
   localparam int REPORT_MAX  = 10;

   // one result word as the block should present it
   typedef struct packed {
      logic       status;
      logic [7:0] letter_a;
      logic [7:0] letter_b;
      logic [7:0] letter_c;
      logic       name_present;
      logic [3:0] name_length;
      logic [3:0] char_index;
      logic [7:0] name_char;
      logic       last_result;
   } name_word_type;

   // predictor of the extractor plus the store of words still to arrive
   class name_scoreboard;
      logic [7:0]  byte_pos;
      logic [7:0]  vend_hi;
      logic [7:0]  vend_lo;
      bit          hdr_ok;
      bit          capturing;
      bit          name_found;
      logic [7:0]  name_buf [NAME_CAP];
      int unsigned kept;
      int unsigned trimmed;
      name_word_type expected_words [$];
      int          mismatches;
      int          runs;
      int          bytes_in;
      int          words_out;
      int          short_runs;
      int          named_runs;

      function new();
         mismatches = 0;
         runs       = 0;
         bytes_in   = 0;
         words_out  = 0;
         short_runs = 0;
         named_runs = 0;
         start_run();
      endfunction

      function void start_run();
         byte_pos   = 8'd0;
         vend_hi    = 8'd0;
         vend_lo    = 8'd0;
         hdr_ok     = 1'b0;
         capturing  = 1'b0;
         name_found = 1'b0;
         kept       = 0;
         trimmed    = 0;
      endfunction

      // one byte at offset p of the base block
      function void absorb(int p, logic [7:0] b);
         int         rel;
         logic [7:0] c;
         if (p == VENDOR_HI_POS) vend_hi = b;
         if (p == VENDOR_LO_POS) vend_lo = b;
         if (p < DESC_START || p >= DESC_END) return;
         rel = (p - DESC_START) % DESC_BYTES;
         if (rel == REL_HDR_FIRST) begin
            capturing = 1'b0;
            hdr_ok    = !name_found && b == CHAR_NUL;
         end else if (rel == REL_HDR_SECOND || rel == REL_HDR_THIRD) begin
            hdr_ok = hdr_ok && b == CHAR_NUL;
         end else if (rel == REL_TAG) begin
            if (hdr_ok && b == NAME_TAG) begin
               name_found = 1'b1;
               capturing  = 1'b1;
            end
            hdr_ok = 1'b0;
         end else if (rel > REL_RESERVED && capturing) begin
            if (b == CHAR_LF || b == CHAR_CR || b == CHAR_NUL) begin
               capturing = 1'b0;
            end else if (kept < NAME_CAP) begin
               // anything unprintable is held as a space
               c = (b >= CHAR_SPACE && b <= CHAR_TILDE) ? b : CHAR_SPACE;
               name_buf[kept] = c;
               kept++;
               if (c != CHAR_SPACE) trimmed = kept;
               if (kept >= NAME_CAP) capturing = 1'b0;
            end else begin
               capturing = 1'b0;
            end
            if (rel == REL_LAST) capturing = 1'b0;
         end
      endfunction

      // accepted input word; on the last byte the run's words are queued
      function void note_byte(logic [7:0] b, logic last);
         bit          short_buf;
         int unsigned n;
         int unsigned n_words;
         name_word_type w;
         bytes_in++;
         if (byte_pos < BLOCK_LEN) begin
            absorb(int'(byte_pos), b);
            byte_pos++;
         end
         if (!last) return;
         short_buf  = byte_pos < BLOCK_LEN;
         n          = short_buf ? 0 : trimmed;
         n_words    = (n == 0) ? 1 : n;
         w.status   = short_buf;
         w.letter_a = {LETTER_BASE, vend_hi[6:2]};
         w.letter_b = {LETTER_BASE, vend_hi[1:0], vend_lo[7:5]};
         w.letter_c = {LETTER_BASE, vend_lo[4:0]};
         w.name_present = !short_buf && kept > 0;
         w.name_length = n[3:0];
         for (int k = 0; k < n_words; k++) begin
            w.char_index  = k[3:0];
            w.name_char   = (n > 0) ? name_buf[k] : CHAR_NUL;
            w.last_result = (k + 1 >= n);
            expected_words.push_back(w);
         end
         runs++;
         if (short_buf) short_runs++;
         if (w.name_present) named_runs++;
         start_run();
      endfunction

      // accepted result word against the oldest expectation
      function void check_word(name_word_type got);
         name_word_type want;
         bit         bad;
         words_out++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] unexpected result word: idx=%0d ch=%h last=%0d",
                        $realtime, got.char_index, got.name_char, got.last_result);
            return;
         end
         want = expected_words.pop_front();
         bad = (got.status !== want.status) || (got.letter_a !== want.letter_a) ||
               (got.letter_b !== want.letter_b) || (got.letter_c !== want.letter_c) ||
               (got.name_present !== want.name_present) ||
               (got.name_length !== want.name_length) ||
               (got.char_index !== want.char_index) || (got.name_char !== want.name_char) ||
               (got.last_result !== want.last_result);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("[%0t] mismatch exp: st=%0d id=%s%s%s hn=%0d len=%0d idx=%0d ch=%h last=%0d",
                        $realtime, want.status, want.letter_a, want.letter_b, want.letter_c,
                        want.name_present, want.name_length, want.char_index, want.name_char,
                        want.last_result);
               $display("[%0t] mismatch act: st=%0d id=%s%s%s hn=%0d len=%0d idx=%0d ch=%h last=%0d",
                        $realtime, got.status, got.letter_a, got.letter_b, got.letter_c,
                        got.name_present, got.name_length, got.char_index, got.name_char,
                        got.last_result);
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   edidx_req_if req_ch ();
   edidx_rsp_if rsp_ch ();

   edid_id_and_name_extractor_top #(
      .NAME_CAPACITY (NAME_CAP)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   name_scoreboard sb;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             idle_cycles;
   logic [7:0]     edid_buf [0:MAX_RUN-1];
   int             run_len;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // accepted words on both channels
   always @(posedge clock) begin
      name_word_type got;
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_byte(req_ch.edid_byte, req_ch.last_byte);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status       = rsp_ch.status;
         got.letter_a     = rsp_ch.vendor_letter_a;
         got.letter_b     = rsp_ch.vendor_letter_b;
         got.letter_c     = rsp_ch.vendor_letter_c;
         got.name_present = rsp_ch.name_present;
         got.name_length  = rsp_ch.name_length;
         got.char_index   = rsp_ch.char_index;
         got.name_char    = rsp_ch.name_char;
         got.last_result  = rsp_ch.last_result;
         sb.check_word(got);
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // one byte through the input channel, with an optional gap before it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         @(negedge clock) req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.edid_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_run();
      for (int i = 0; i < run_len; i++) send_byte(edid_buf[i], i == run_len - 1);
   endtask

   // sender holds off until every queued word has come back
   task automatic hold_until_drained();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // random buffer whose descriptors all start with a nonzero byte
   task automatic fill_plain();
      for (int i = 0; i < MAX_RUN; i++) edid_buf[i] = 8'($urandom_range(255));
      for (int s = 0; s < 4; s++)
         edid_buf[DESC_START + DESC_BYTES * s] = 8'($urandom_range(1, 255));
      run_len = int'(BLOCK_LEN);
   endtask

   task automatic put_header(input int slot, input logic [7:0] h0, input logic [7:0] h1,
                             input logic [7:0] h2, input logic [7:0] tag);
      int base;
      base = DESC_START + DESC_BYTES * slot;
      edid_buf[base]     = h0;
      edid_buf[base + 1] = h1;
      edid_buf[base + 2] = h2;
      edid_buf[base + 3] = tag;
   endtask

   // name descriptor with text, terminator and space padding
   task automatic put_name(input int slot, input string s, input logic [7:0] term);
      int base;
      base = DESC_START + DESC_BYTES * slot;
      put_header(slot, CHAR_NUL, CHAR_NUL, CHAR_NUL, NAME_TAG);
      edid_buf[base + 4] = CHAR_NUL;
      for (int i = 5; i < DESC_BYTES; i++) edid_buf[base + i] = CHAR_SPACE;
      for (int i = 0; i < s.len() && i < NAME_CAP; i++) edid_buf[base + 5 + i] = s.getc(i);
      if (s.len() < NAME_CAP) edid_buf[base + 5 + s.len()] = term;
   endtask

   // name descriptor with random content, mostly printable
   task automatic put_random_name(input int slot);
      int base;
      int len;
      int r;
      base = DESC_START + DESC_BYTES * slot;
      put_header(slot, CHAR_NUL, CHAR_NUL, CHAR_NUL, NAME_TAG);
      edid_buf[base + 4] = 8'($urandom_range(255));
      len = $urandom_range(0, NAME_CAP);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(19);
         if (r < 2)      edid_buf[base + 5 + i] = 8'($urandom_range(255));
         else if (r < 5) edid_buf[base + 5 + i] = CHAR_SPACE;
         else            edid_buf[base + 5 + i] = 8'($urandom_range(33, 126));
      end
      for (int i = 5 + len; i < DESC_BYTES; i++)
         edid_buf[base + i] = $urandom_range(1) ? CHAR_SPACE : 8'($urandom_range(255));
      if (len < NAME_CAP) begin
         r = $urandom_range(3);
         if (r == 0)      edid_buf[base + 5 + len] = CHAR_LF;
         else if (r == 1) edid_buf[base + 5 + len] = CHAR_CR;
         else if (r == 2) edid_buf[base + 5 + len] = CHAR_NUL;
      end
   endtask

   // random buffer: mostly well-formed, with noisy and broken descriptors
   task automatic make_random_run();
      int r;
      for (int i = 0; i < MAX_RUN; i++) edid_buf[i] = 8'($urandom_range(255));
      for (int s = 0; s < 4; s++) begin
         r = $urandom_range(9);
         if (r >= 4 && r <= 6)
            put_header(s, CHAR_NUL, CHAR_NUL, CHAR_NUL,
                       $urandom_range(1) ? 8'hFD : 8'($urandom_range(255)));
         else if (r == 7)
            put_header(s, CHAR_NUL, $urandom_range(1) ? CHAR_NUL : 8'h01,
                       8'($urandom_range(1, 255)), NAME_TAG);
         else if (r >= 8)
            edid_buf[DESC_START + DESC_BYTES * s] = 8'($urandom_range(1, 255));
      end
      if ($urandom_range(9) < 8) put_random_name($urandom_range(3));
      if ($urandom_range(4) == 0) put_random_name($urandom_range(3));
      r = $urandom_range(19);
      if (r < 2)      run_len = $urandom_range(1, BLOCK_LEN - 1);
      else if (r < 4) run_len = BLOCK_LEN + $urandom_range(1, MAX_RUN - BLOCK_LEN);
      else            run_len = int'(BLOCK_LEN);
   endtask

   // directed buffers: letter extremes, name corners, short and long buffers
   task automatic run_directed();
      fill_plain();
      edid_buf[VENDOR_HI_POS] = 8'hFF;
      edid_buf[VENDOR_LO_POS] = 8'hFF;
      put_name(0, "MONITOR", CHAR_LF);
      send_run();

      // full-capacity name in the last descriptor, no terminator
      fill_plain();
      edid_buf[VENDOR_HI_POS] = 8'h00;
      edid_buf[VENDOR_LO_POS] = 8'h00;
      put_name(3, "ABCDEFGHIJKLM", CHAR_LF);
      send_run();

      // only the first name descriptor counts
      fill_plain();
      put_name(1, "FIRST", CHAR_CR);
      put_name(2, "SECOND", CHAR_LF);
      send_run();

      // unprintable bytes become spaces, trailing ones trimmed
      fill_plain();
      put_name(0, "", CHAR_SPACE);
      edid_buf[DESC_START + 5]  = 8'h7F;
      edid_buf[DESC_START + 6]  = "X";
      edid_buf[DESC_START + 7]  = 8'h80;
      edid_buf[DESC_START + 8]  = 8'h1F;
      edid_buf[DESC_START + 9]  = "Y";
      edid_buf[DESC_START + 10] = 8'hFF;
      edid_buf[DESC_START + 11] = CHAR_SPACE;
      edid_buf[DESC_START + 12] = CHAR_NUL;
      send_run();

      // name of spaces only: captured, nothing left after trimming
      fill_plain();
      put_name(2, "    ", CHAR_LF);
      send_run();

      // headers that miss by one byte
      fill_plain();
      put_header(0, CHAR_NUL, CHAR_NUL, 8'h01, NAME_TAG);
      put_header(1, CHAR_NUL, CHAR_NUL, CHAR_NUL, 8'hFD);
      put_header(2, 8'h01, CHAR_NUL, CHAR_NUL, NAME_TAG);
      put_header(3, CHAR_NUL, 8'h01, CHAR_NUL, NAME_TAG);
      send_run();

      // terminator at the first name byte
      fill_plain();
      put_name(1, "", CHAR_CR);
      send_run();

      // trailing spaces in a full-length name, and a single letter
      fill_plain();
      put_name(0, "HELLO        ", CHAR_LF);
      send_run();
      fill_plain();
      put_name(3, "Z", CHAR_NUL);
      send_run();

      // bytes past the block are ignored
      fill_plain();
      put_name(2, "EXTRA", CHAR_LF);
      run_len = MAX_RUN;
      send_run();

      // short buffers: one byte short, single byte, vendor low byte missing, ending after the vendor bytes
      fill_plain();
      put_name(0, "SHORT", CHAR_LF);
      run_len = BLOCK_LEN - 1;
      send_run();
      fill_plain();
      edid_buf[0] = 8'hFF;
      run_len = 1;
      send_run();
      fill_plain();
      edid_buf[VENDOR_HI_POS] = 8'hAB;
      run_len = VENDOR_HI_POS + 1;
      send_run();
      fill_plain();
      run_len = VENDOR_LO_POS + 1;
      send_run();
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.edid_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      idle_cycles      = 0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // idling phases: none, sender only, receiver only, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 30 : 0;
         recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 30 : 0;
         if (ph == 0) run_directed();
         for (int r = 0; r < 8; r++) begin
            make_random_run();
            send_run();
            if (r == 3) hold_until_drained();
         end
         hold_until_drained();
      end

      repeat (16) @(posedge clock);
      $display("covered %0d runs (%0d bytes, %0d short, %0d with a name), %0d result words",
               sb.runs, sb.bytes_in, sb.short_runs, sb.named_runs, sb.words_out);
      $display("idling phases: none, sender, receiver, both; %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
